/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the bisection root finder.
// Depends on nothing; a file that asserts takes this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/bsr_pkg.sv */
// Package of the bisection root finder: widths, constants, beat types and the FSM state.
// Depends on nothing; the core, the cell and the cell row use it by scoped names.
`timescale 1ns / 1ps

package bsr_pkg;

  // Number format and search limits.
  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int MAX_ITER = 64;
  localparam int ITER_W   = $clog2(MAX_ITER + 1);
  localparam int TOL_W    = 31;
  localparam int LIM_W    = TOL_W + 1;
  localparam int DIFF_W   = DATA_W + 2;

  // Squaring chain: one multiplier digit per cell.
  localparam int DIGIT_W   = 16;
  localparam int NUM_CELLS = (DATA_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MC_W      = DATA_W + DIGIT_W * (NUM_CELLS - 1);
  localparam int PROD_W    = MC_W + DIGIT_W;
  localparam int ACC_W     = 2 * DATA_W + 2;
  localparam int CNT_W     = $clog2(NUM_CELLS + 1);

  // f(x) scaled by 2^(2F-2): 3*2^(2F-2) + 2^(F-2)*x - x^2.
  localparam logic signed [ACC_W-1:0] POLY_K0 = ACC_W'(3) <<< (2 * FRAC_W - 2);
  localparam int POLY_K1_SH = FRAC_W - 2;

  // Configuration port.
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [TOL_W-1:0]  TOL_RESET     = 31'd66;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_MUL,
    ST_DEC
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interval_low;
    logic signed [DATA_W-1:0] interval_high;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] root;
    logic [ITER_W-1:0]        iterations;
    logic                     limit_hit;
  } out_beat_t;

  // What one cell hands to the next: shifted multiplicand, remaining
  // multiplier digits and the running value of the polynomial.
  typedef struct packed {
    logic [MC_W-1:0]         mcand;
    logic [DATA_W-1:0]       rem;
    logic signed [ACC_W-1:0] acc;
  } cell_beat_t;

endpackage

/* rtl/bisection_root_finder_core.sv */
// Top level of the bisection root finder: APB register, control FSM and result register.
// Depends on bsr_pkg, bsr_cell_row and assert_macros.svh.
`timescale 1ns / 1ps
//
// Usage
//   An interval beat is taken on in_data at a rising edge with start high and
//   busy low. The block bisects it for a root of f(x) = -4x^2 + x + 3 while
//   half the width exceeds the tolerance register, up to MAX_ITER steps, and
//   returns one result beat on out_data, marked by out_valid for exactly one cycle.
//   An interval that needs no step gives its result in the cycle after it is
//   taken and leaves busy low. Otherwise the block first finds the sign of
//   f at the low end, then runs each step through the states FEED and MUL,
//   while the two-cell squaring chain works, and DEC, which picks the half
//   interval. After the last step the result appears in the same cycle in
//   which busy falls, so the next start may follow at once. The chain length
//   and the decision state set the length of each step. Reset (rst_n low at
//   a clock edge) returns the FSM to idle, drops any beat in flight and
//   loads the tolerance with 66 (about 0.001). The receiver cannot stall: a
//   result is gone after its strobe cycle. The user must write the tolerance
//   over APB at byte address 0 only while idle; the block does not enforce it.
//

`include "assert_macros.svh"

module bisection_root_finder_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // Interval channel
  input  logic                         start,
  output logic                         busy,
  input  bsr_pkg::in_beat_t            in_data,
  // Result channel
  output logic                         out_valid,
  output bsr_pkg::out_beat_t           out_data,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsr_pkg::APB_AW-1:0]   paddr,
  input  logic [bsr_pkg::APB_DW-1:0]   pwdata,
  output logic [bsr_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  // Floor of the mean of two points, from the exact wider sum.
  function automatic logic signed [bsr_pkg::DATA_W-1:0] mid_of(
    input logic signed [bsr_pkg::DATA_W-1:0] p,
    input logic signed [bsr_pkg::DATA_W-1:0] q
  );
    logic signed [bsr_pkg::DATA_W:0] s;
    s = (bsr_pkg::DATA_W+1)'(p) + (bsr_pkg::DATA_W+1)'(q);
    return $signed(s[bsr_pkg::DATA_W:1]);
  endfunction

  // True when hi - lo exceeds twice the tolerance.
  function automatic logic wider(
    input logic signed [bsr_pkg::DATA_W-1:0] hi,
    input logic signed [bsr_pkg::DATA_W-1:0] lo,
    input logic [bsr_pkg::LIM_W-1:0]         lim2
  );
    logic signed [bsr_pkg::DIFF_W-1:0] d;
    d = bsr_pkg::DIFF_W'(hi) - bsr_pkg::DIFF_W'(lo);
    return d > $signed(bsr_pkg::DIFF_W'(lim2));
  endfunction

  bsr_pkg::state_t                  state_r, state_nxt;
  logic [bsr_pkg::TOL_W-1:0]        tol_r;
  logic [bsr_pkg::LIM_W-1:0]        lim2;
  logic signed [bsr_pkg::DATA_W-1:0] a_r, a_nxt;
  logic signed [bsr_pkg::DATA_W-1:0] b_r, b_nxt;
  logic signed [bsr_pkg::DATA_W-1:0] c_r, c_nxt;
  logic signed [bsr_pkg::DATA_W-1:0] mid_a_r, mid_a_nxt;
  logic signed [bsr_pkg::DATA_W-1:0] mid_b_r, mid_b_nxt;
  logic                             cond_a_r, cond_a_nxt;
  logic                             cond_b_r, cond_b_nxt;
  logic [bsr_pkg::ITER_W-1:0]       n_r, n_nxt;
  logic [bsr_pkg::CNT_W-1:0]        mul_cnt_r, mul_cnt_nxt;
  logic                             eval_a_r, eval_a_nxt;
  logic                             sa_pos_r, sa_pos_nxt;
  logic                             sa_neg_r, sa_neg_nxt;
  logic                             out_valid_r, out_valid_nxt;
  bsr_pkg::out_beat_t               out_data_r, out_data_nxt;
  logic signed [bsr_pkg::DATA_W-1:0] chain_x;
  logic signed [bsr_pkg::ACC_W-1:0]  chain_g;
  logic                             sc_pos, sc_neg, keep_high, go_on;
  logic                             cfg_write;

  // Configuration register.
  assign cfg_write = psel & penable & pwrite & (paddr == bsr_pkg::REG_TOLERANCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= bsr_pkg::TOL_RESET;
    end else if (cfg_write) begin
      tol_r <= pwdata[bsr_pkg::TOL_W-1:0];
    end
  end

  assign prdata = bsr_pkg::APB_DW'(tol_r);
  assign pready = 1'b1;
  assign lim2   = {tol_r, 1'b0};

  // Polynomial evaluation: the low end first, then each midpoint.
  assign chain_x = eval_a_r ? a_r : c_r;

  bsr_cell_row u_row (
    .clk (clk),
    .x   (chain_x),
    .g   (chain_g)
  );

  assign sc_pos    = (chain_g > 0);
  assign sc_neg    = chain_g[bsr_pkg::ACC_W-1];
  assign keep_high = (sa_pos_r & sc_pos) | (sa_neg_r & sc_neg);
  assign go_on     = keep_high ? cond_a_r : cond_b_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, datapath updates and the result beat.
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    mid_a_nxt     = mid_a_r;
    mid_b_nxt     = mid_b_r;
    cond_a_nxt    = cond_a_r;
    cond_b_nxt    = cond_b_r;
    n_nxt         = n_r;
    mul_cnt_nxt   = mul_cnt_r;
    eval_a_nxt    = eval_a_r;
    sa_pos_nxt    = sa_pos_r;
    sa_neg_nxt    = sa_neg_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      bsr_pkg::ST_IDLE: begin
        if (start) begin
          a_nxt      = in_data.interval_low;
          b_nxt      = in_data.interval_high;
          c_nxt      = mid_of(in_data.interval_low, in_data.interval_high);
          n_nxt      = '0;
          eval_a_nxt = 1'b1;
          if (wider(in_data.interval_high, in_data.interval_low, lim2)) begin
            state_nxt = bsr_pkg::ST_FEED;
          end else begin
            // Already narrow enough: the midpoint is the answer.
            out_valid_nxt           = 1'b1;
            out_data_nxt.root       = mid_of(in_data.interval_low, in_data.interval_high);
            out_data_nxt.iterations = '0;
            out_data_nxt.limit_hit  = 1'b0;
          end
        end
      end
      bsr_pkg::ST_FEED: begin
        mul_cnt_nxt = '0;
        state_nxt   = bsr_pkg::ST_MUL;
      end
      bsr_pkg::ST_MUL: begin
        // Both possible next intervals are prepared while the chain works.
        mid_a_nxt   = mid_of(c_r, b_r);
        mid_b_nxt   = mid_of(a_r, c_r);
        cond_a_nxt  = wider(b_r, c_r, lim2);
        cond_b_nxt  = wider(c_r, a_r, lim2);
        mul_cnt_nxt = mul_cnt_r + bsr_pkg::CNT_W'(1);
        if (mul_cnt_r == bsr_pkg::CNT_W'(bsr_pkg::NUM_CELLS - 2)) begin
          state_nxt = bsr_pkg::ST_DEC;
        end
      end
      bsr_pkg::ST_DEC: begin
        if (eval_a_r) begin
          // The sign at the low end never changes within one interval.
          sa_pos_nxt = sc_pos;
          sa_neg_nxt = sc_neg;
          eval_a_nxt = 1'b0;
          state_nxt  = bsr_pkg::ST_FEED;
        end else begin
          n_nxt = n_r + bsr_pkg::ITER_W'(1);
          if (keep_high) begin
            a_nxt = c_r;
          end else begin
            b_nxt = c_r;
          end
          if (go_on && (n_nxt != bsr_pkg::ITER_W'(bsr_pkg::MAX_ITER))) begin
            c_nxt     = keep_high ? mid_a_r : mid_b_r;
            state_nxt = bsr_pkg::ST_FEED;
          end else begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.root       = c_r;
            out_data_nxt.iterations = n_nxt;
            out_data_nxt.limit_hit  = go_on;
            state_nxt               = bsr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = bsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      eval_a_r    <= 1'b0;
      mul_cnt_r   <= '0;
      n_r         <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      eval_a_r    <= eval_a_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
      n_r         <= n_nxt;
    end
  end

  // Interval, candidates and result payload.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    mid_a_r    <= mid_a_nxt;
    mid_b_r    <= mid_b_nxt;
    cond_a_r   <= cond_a_nxt;
    cond_b_r   <= cond_b_nxt;
    sa_pos_r   <= sa_pos_nxt;
    sa_neg_r   <= sa_neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != bsr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the control logic.
  `ASSERT_NEXT(a_accept_moves, clk, rst_n, start && !busy, busy || out_valid)
  `ASSERT_IMPLIES(a_result_when_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_IMPLIES(a_count_in_range, clk, rst_n, out_valid, out_data.iterations <= bsr_pkg::ITER_W'(bsr_pkg::MAX_ITER))
  `ASSERT_IMPLIES(a_limit_at_max, clk, rst_n, out_valid && out_data.limit_hit, out_data.iterations == bsr_pkg::ITER_W'(bsr_pkg::MAX_ITER))

endmodule

/* rtl/bsr_cell.sv */
// One cell of the squaring chain: subtracts one digit's partial product.
// Depends on bsr_pkg.
`timescale 1ns / 1ps

module bsr_cell (
  input  logic               clk,
  input  bsr_pkg::cell_beat_t beat_in,
  output bsr_pkg::cell_beat_t beat_out
);

  logic [bsr_pkg::PROD_W-1:0]        prod;
  logic signed [bsr_pkg::ACC_W-1:0]  prod_ext;
  bsr_pkg::cell_beat_t               beat_r;
  bsr_pkg::cell_beat_t               beat_nxt;

  // Partial product of the multiplicand and the lowest remaining digit.
  assign prod     = beat_in.mcand * beat_in.rem[bsr_pkg::DIGIT_W-1:0];
  assign prod_ext = $signed(bsr_pkg::ACC_W'(prod));

  // Take the product off the running value and move to the next digit.
  always_comb begin
    beat_nxt.acc   = beat_in.acc - prod_ext;
    beat_nxt.mcand = beat_in.mcand << bsr_pkg::DIGIT_W;
    beat_nxt.rem   = beat_in.rem >> bsr_pkg::DIGIT_W;
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign beat_out = beat_r;

endmodule

/* rtl/bsr_cell_row.sv */
// Row of squaring cells that evaluates the scaled polynomial at one point.
// Depends on bsr_pkg and bsr_cell.
`timescale 1ns / 1ps

module bsr_cell_row (
  input  logic                             clk,
  input  logic signed [bsr_pkg::DATA_W-1:0] x,
  output logic signed [bsr_pkg::ACC_W-1:0]  g
);

  bsr_pkg::cell_beat_t              link [bsr_pkg::NUM_CELLS+1];
  logic [bsr_pkg::DATA_W-1:0]       mag;
  logic signed [bsr_pkg::ACC_W-1:0] base;

  // Magnitude of the point; the square only needs that.
  assign mag = x[bsr_pkg::DATA_W-1] ? $unsigned(~x + bsr_pkg::DATA_W'(1)) : $unsigned(x);

  // Constant and linear terms enter the chain as the starting value.
  assign base = bsr_pkg::POLY_K0 + (bsr_pkg::ACC_W'(x) <<< bsr_pkg::POLY_K1_SH);

  assign link[0] = '{mcand: bsr_pkg::MC_W'(mag), rem: mag, acc: base};

  // Each cell removes one digit's share of x squared and registers its result.
  for (genvar k = 0; k < bsr_pkg::NUM_CELLS; k++) begin : g_cell
    bsr_cell u_cell (
      .clk      (clk),
      .beat_in  (link[k]),
      .beat_out (link[k+1])
    );
  end

  assign g = link[bsr_pkg::NUM_CELLS].acc;

endmodule
